@@ src/sspd_pkg.sv @@
`timescale 1ns / 1ps

package sspd_pkg;

    localparam int unsigned MAX_PARAMS = 253;

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] LEN_MIN  = 8'd2;
    localparam logic [8:0] LEN_MAX  = 9'(MAX_PARAMS + 2);
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    localparam logic [7:0] SERVO_ID_RESET = 8'd1;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [2:0] KIND_PARAM   = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_BADSUM  = 3'd2;
    localparam logic [2:0] KIND_WRONGID = 3'd3;
    localparam logic [2:0] KIND_BADLEN  = 3'd4;

    typedef enum logic [6:0] {
        PH_HUNT1 = 7'b0000001,
        PH_HUNT2 = 7'b0000010,
        PH_ID    = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_ERR   = 7'b0010000,
        PH_PARAM = 7'b0100000,
        PH_CSUM  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] param_byte;
        logic [7:0] param_index;
        logic [7:0] error_flags;
        logic       last;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] running_sum;
        logic [7:0] params_left;
        logic [7:0] param_count;
        logic [7:0] error_byte;
        logic       id_matched;
    } ctx_t;

    localparam ctx_t CTX_HUNT = '{
        phase:       PH_HUNT1,
        running_sum: 8'd0,
        params_left: 8'd0,
        param_count: 8'd0,
        error_byte:  8'd0,
        id_matched:  1'b0
    };

endpackage

@@ src/sspd_in_stage.sv @@
`timescale 1ns / 1ps

module sspd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sspd_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output sspd_pkg::item_t item
);
    import sspd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ src/sspd_parser.sv @@
`timescale 1ns / 1ps

module sspd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  sspd_pkg::item_t   item,
    input  logic [7:0]        servo_id,
    output logic              res_valid,
    output sspd_pkg::result_t res
);
    import sspd_pkg::*;

    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    logic [7:0] b;
    logic [7:0] sum_plus;

    assign b        = item.rx_byte;
    assign sum_plus = ctx_reg.running_sum + b;

    always_comb begin
        ctx_next  = ctx_reg;
        res_valid = 1'b0;
        res       = '0;
        if (item.op == OP_TIMEOUT) begin
            ctx_next = CTX_HUNT;
        end else begin
            case (ctx_reg.phase)
                PH_HUNT2: begin
                    ctx_next = CTX_HUNT;
                    if (b == HDR_BYTE) begin
                        ctx_next       = ctx_reg;
                        ctx_next.phase = PH_ID;
                    end
                end
                PH_ID: begin
                    // extra header bytes are skipped
                    if (b != HDR_BYTE) begin
                        ctx_next.id_matched  = (b == servo_id);
                        ctx_next.running_sum = b;
                        ctx_next.phase       = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if ({1'b0, b} inside {[{1'b0, LEN_MIN}:LEN_MAX]}) begin
                        ctx_next.params_left = b - LEN_OVERHEAD;
                        ctx_next.running_sum = sum_plus;
                        ctx_next.phase       = PH_ERR;
                    end else begin
                        ctx_next  = CTX_HUNT;
                        res_valid = 1'b1;
                        res.kind  = KIND_BADLEN;
                        res.last  = 1'b1;
                    end
                end
                PH_ERR: begin
                    ctx_next.error_byte  = b;
                    ctx_next.running_sum = sum_plus;
                    ctx_next.param_count = 8'd0;
                    ctx_next.phase       = (ctx_reg.params_left == 8'd0) ? PH_CSUM : PH_PARAM;
                end
                PH_PARAM: begin
                    ctx_next.running_sum = sum_plus;
                    ctx_next.param_count = ctx_reg.param_count + 8'd1;
                    ctx_next.params_left = ctx_reg.params_left - 8'd1;
                    if (ctx_reg.params_left == 8'd1) begin
                        ctx_next.phase = PH_CSUM;
                    end
                    res_valid       = 1'b1;
                    res.kind        = KIND_PARAM;
                    res.param_byte  = b;
                    res.param_index = ctx_reg.param_count;
                    res.error_flags = ctx_reg.error_byte;
                end
                PH_CSUM: begin
                    ctx_next        = CTX_HUNT;
                    res_valid       = 1'b1;
                    res.error_flags = ctx_reg.error_byte;
                    res.last        = 1'b1;
                    if (b != ~ctx_reg.running_sum) begin
                        res.kind = KIND_BADSUM;
                    end else if (!ctx_reg.id_matched) begin
                        res.kind = KIND_WRONGID;
                    end else begin
                        res.kind = KIND_OK;
                    end
                end
                default: begin
                    ctx_next = CTX_HUNT;
                    if (b == HDR_BYTE) begin
                        ctx_next.phase = PH_HUNT2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= CTX_HUNT;
        end else if (advance) begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

@@ src/sspd_out_stage.sv @@
`timescale 1ns / 1ps

module sspd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  sspd_pkg::result_t res,
    input  logic              m_ready,
    output logic              m_valid,
    output sspd_pkg::result_t m_res
);
    import sspd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

@@ src/servo_status_packet_deframer_core.sv @@
`timescale 1ns / 1ps

// status packet deframer for a half-duplex servo bus
// input channel (s_*): one request per received byte (s_op = 0) or a
//   receive timeout (s_op = 1) that drops any packet in progress
// result channel (m_*): one parameter byte with its index per parameter,
//   then a final status (ok, bad checksum, wrong id, bad length) with last set
// cfg_wr_en / cfg_wr_data write the expected servo id (reset value 1);
//   write only while no request is in flight
// throughput: one request per cycle while m_ready does not stall, set by the single
//   parse step between the input register and the result register
// s_ready stays high while the input register is empty or drains this cycle;
//   a stalled m_ready holds the result and lets one more request wait
//   in the input register before s_ready drops
// reset (aresetn low, synchronous) empties both registers, returns to the
//   header hunt and restores the servo id to 1
module servo_status_packet_deframer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_param_byte,
    output logic [7:0] m_param_index,
    output logic [7:0] m_error_flags,
    output logic       m_last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import sspd_pkg::*;

    item_t      s_item;
    item_t      item;
    logic       item_valid;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    m_res;
    logic [7:0] servo_id_reg;

    assign s_item.op      = s_op;
    assign s_item.rx_byte = s_rx_byte;

    assign advance = item_valid && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_id_reg <= SERVO_ID_RESET;
        end else if (cfg_wr_en) begin
            servo_id_reg <= cfg_wr_data;
        end
    end

    sspd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sspd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .servo_id  (servo_id_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sspd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_res   (m_res)
    );

    assign m_kind        = m_res.kind;
    assign m_param_byte  = m_res.param_byte;
    assign m_param_index = m_res.param_index;
    assign m_error_flags = m_res.error_flags;
    assign m_last        = m_res.last;

    a_param_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_PARAM) |-> !m_last)
        else $error("parameter result marked last");

    a_badlen_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_BADLEN) |->
            (m_error_flags == 8'd0 && m_param_index == 8'd0 && m_param_byte == 8'd0))
        else $error("bad length result carries packet data");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(item_valid))
        else $error("result appeared without a request");

    a_timeout_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.op == OP_TIMEOUT) |-> !res_valid)
        else $error("timeout produced a result");

endmodule

@@ test/deframe_checker.sv @@
`timescale 1ns / 1ps

module deframe_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_kind,
    input  logic [7:0] m_param_byte,
    input  logic [7:0] m_param_index,
    input  logic [7:0] m_error_flags,
    input  logic       m_last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         fail_count,
    output int         outstanding
);
    import sspd_pkg::*;

    ctx_t       frame_ctx;
    logic [7:0] expected_id;
    result_t    status_due[$];
    result_t    oldest;

    task automatic deframe_byte(input logic op, input logic [7:0] b);
        result_t r;
        logic    emit;
        r = '0;
        emit = 1'b0;
        if (op == OP_TIMEOUT) begin
            frame_ctx = CTX_HUNT;
        end else begin
            case (frame_ctx.phase)
                PH_HUNT2: begin
                    if (b == HDR_BYTE) begin
                        frame_ctx.phase = PH_ID;
                    end else begin
                        frame_ctx = CTX_HUNT;
                    end
                end
                PH_ID: begin
                    // repeated header bytes are skipped
                    if (b != HDR_BYTE) begin
                        frame_ctx.id_matched = (b == expected_id);
                        frame_ctx.running_sum = b;
                        frame_ctx.phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b < LEN_MIN || 9'(b) > LEN_MAX) begin
                        frame_ctx = CTX_HUNT;
                        r.kind = KIND_BADLEN;
                        r.last = 1'b1;
                        emit = 1'b1;
                    end else begin
                        frame_ctx.params_left = b - LEN_OVERHEAD;
                        frame_ctx.running_sum = frame_ctx.running_sum + b;
                        frame_ctx.phase = PH_ERR;
                    end
                end
                PH_ERR: begin
                    frame_ctx.error_byte = b;
                    frame_ctx.running_sum = frame_ctx.running_sum + b;
                    frame_ctx.param_count = 8'd0;
                    frame_ctx.phase = (frame_ctx.params_left == 8'd0) ? PH_CSUM : PH_PARAM;
                end
                PH_PARAM: begin
                    r.kind = KIND_PARAM;
                    r.param_byte = b;
                    r.param_index = frame_ctx.param_count;
                    r.error_flags = frame_ctx.error_byte;
                    emit = 1'b1;
                    frame_ctx.running_sum = frame_ctx.running_sum + b;
                    frame_ctx.param_count = frame_ctx.param_count + 8'd1;
                    frame_ctx.params_left = frame_ctx.params_left - 8'd1;
                    if (frame_ctx.params_left == 8'd0) begin
                        frame_ctx.phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    // bad checksum wins over wrong id
                    if (b != ~frame_ctx.running_sum) begin
                        r.kind = KIND_BADSUM;
                    end else if (!frame_ctx.id_matched) begin
                        r.kind = KIND_WRONGID;
                    end else begin
                        r.kind = KIND_OK;
                    end
                    r.error_flags = frame_ctx.error_byte;
                    r.last = 1'b1;
                    emit = 1'b1;
                    frame_ctx = CTX_HUNT;
                end
                default: begin
                    frame_ctx = CTX_HUNT;
                    if (b == HDR_BYTE) begin
                        frame_ctx.phase = PH_HUNT2;
                    end
                end
            endcase
        end
        if (emit) begin
            status_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_ctx = CTX_HUNT;
            expected_id = SERVO_ID_RESET;
            status_due.delete();
        end else begin
            if (cfg_wr_en) begin
                expected_id = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                deframe_byte(s_op, s_rx_byte);
            end
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    $error("unexpected result: kind %0d, byte %0d, index %0d",
                           m_kind, m_param_byte, m_param_index);
                    fail_count++;
                end else begin
                    oldest = status_due.pop_front();
                    check_field("kind", 8'(oldest.kind), 8'(m_kind));
                    check_field("param_byte", oldest.param_byte, m_param_byte);
                    check_field("param_index", oldest.param_index, m_param_index);
                    check_field("error_flags", oldest.error_flags, m_error_flags);
                    check_field("last", 8'(oldest.last), 8'(m_last));
                end
            end
        end
        outstanding <= status_due.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sspd_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 600;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_op        = OP_BYTE;
    logic [7:0] s_rx_byte   = 8'd0;
    logic       m_ready     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    logic       s_ready;
    logic       m_valid;
    logic [2:0] m_kind;
    logic [7:0] m_param_byte;
    logic [7:0] m_param_index;
    logic [7:0] m_error_flags;
    logic       m_last;

    int         fail_count;
    int         outstanding;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         items_sent    = 0;
    int         stall_cycles  = 0;
    logic [7:0] cur_id        = 8'd1;

    always #6 aclk = ~aclk;

    servo_status_packet_deframer_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_param_byte (m_param_byte),
        .m_param_index(m_param_index),
        .m_error_flags(m_error_flags),
        .m_last       (m_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    deframe_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_param_byte (m_param_byte),
        .m_param_index(m_param_index),
        .m_error_flags(m_error_flags),
        .m_last       (m_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // header, optional extra header bytes, id, length, and for len >= 2 error,
    // params, checksum; a timeout replaces the byte at abort_at if in the frame and ends the send
    task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                               input logic [7:0] err, input bit good_sum,
                               input int extra_ff, input int abort_at);
        logic [7:0] frame[$];
        logic [7:0] sum;
        logic [7:0] p;
        frame.push_back(HDR_BYTE);
        frame.push_back(HDR_BYTE);
        repeat (extra_ff) frame.push_back(HDR_BYTE);
        frame.push_back(id);
        frame.push_back(len);
        if (len >= LEN_MIN) begin
            sum = id + len + err;
            frame.push_back(err);
            for (int i = 0; i < int'(len) - 2; i++) begin
                p = 8'($urandom_range(255));
                sum = sum + p;
                frame.push_back(p);
            end
            frame.push_back(good_sum ? ~sum : ~sum ^ 8'($urandom_range(1, 255)));
        end
        foreach (frame[i]) begin
            if (i == abort_at) begin
                send_item(OP_TIMEOUT, 8'($urandom_range(255)));
                items_sent++;
                break;
            end
            send_item(OP_BYTE, frame[i]);
            items_sent++;
        end
    endtask

    task automatic send_noise();
        int r;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(99);
            if (r < 25) begin
                send_item(OP_TIMEOUT, 8'($urandom_range(255)));
            end else if (r < 50) begin
                send_item(OP_BYTE, HDR_BYTE);
            end else begin
                send_item(OP_BYTE, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] id;
        logic [7:0] len;
        int         pick;
        pick = $urandom_range(99);
        id = ($urandom_range(99) < 75) ? cur_id : 8'($urandom_range(254));
        if (pick < 5) begin
            len = 8'($urandom_range(1));
        end else if (pick < 6) begin
            len = 8'($urandom_range(200, 255));
        end else begin
            len = 8'($urandom_range(2, 10));
        end
        send_packet(id, len, 8'($urandom_range(255)), $urandom_range(99) < 85,
                    ($urandom_range(99) < 15) ? $urandom_range(1, 2) : 0,
                    ($urandom_range(99) < 5) ? $urandom_range(0, int'(len) + 5) : -1);
    endtask

    task automatic run_random(input int target);
        items_sent = 0;
        while (items_sent < target) begin
            if ($urandom_range(99) < 15) begin
                send_noise();
            end else begin
                send_random_frame();
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_servo_id(input logic [7:0] id);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        cur_id = id;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 33;
        recv_idle_pct = 73;
        // broken header, good status, extra header with wrong id,
        // bad length, timeout mid packet
        send_item(OP_BYTE, HDR_BYTE);
        send_item(OP_BYTE, 8'h00);
        send_packet(8'd1, 8'd2, 8'hFF, 1'b1, 0, -1);
        send_packet(8'd5, 8'd3, 8'h00, 1'b1, 1, -1);
        send_packet(8'd1, 8'd1, 8'h00, 1'b1, 0, -1);
        send_packet(8'd1, 8'd4, 8'h00, 1'b1, 0, 3);
        run_random(ITEMS_PER_PHASE);
        drain();

        write_servo_id(8'd253);
        send_idle_pct = 73;
        recv_idle_pct = 33;
        run_random(ITEMS_PER_PHASE);
        drain();

        write_servo_id(8'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_packet(8'd0, 8'd255, 8'h00, 1'b1, 0, -1);
        run_random(ITEMS_PER_PHASE);
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/sspd_pkg.sv
src/sspd_in_stage.sv
src/sspd_parser.sv
src/sspd_out_stage.sv
src/servo_status_packet_deframer_core.sv
test/deframe_checker.sv
test/testbench.sv
